>>> rtl/core/fqmtf_pkg.sv
package fqmtf_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// command codes
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_MTF  = 2'd2;
	localparam logic [1:0] OP_PEEK = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] item_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [15:0] head_value;
		logic               queue_empty;
		logic [4:0]         entry_count;
		logic [1:0]         status;
	} rsp_item_t;

endpackage

>>> rtl/core/fqmtf_addr_unit.sv
module fqmtf_addr_unit
	import fqmtf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic [$clog2(DEPTH)-1:0]   base,
	input  logic [$clog2(DEPTH+1)-1:0] offset,
	output logic [$clog2(DEPTH)-1:0]   addr
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW:0] DEPTH_W = (CW+1)'(DEPTH);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	// circular wrap: base stays below DEPTH and offset does not exceed DEPTH
	always_comb begin
		sum     = (CW+1)'(base) + {1'b0, offset};
		wrapped = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
		addr    = wrapped[AW-1:0];
	end

endmodule

>>> rtl/core/fifo_queue_move_to_front.sv
// Queue with move-to-front, built on a circular single-port RAM and a shared address unit.
// Enqueue, dequeue and peek read the head, then register the result. Move-to-front reads
// and compares from the head on; a key found at position k >= 1 goes to the front by
// shifting entries 0..k-1 back one slot, a key at the head leaves the order alone and a
// miss reads all n entries; every step uses the one RAM port. One command at a time: the
// next command is taken once the result is registered. Reset: asynchronous, active low;
// clears count, head pointer and control, RAM is not cleared.
module fifo_queue_move_to_front
	import fqmtf_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SRCH_RD  = 8'b0000_0010,
		S_SRCH_CMP = 8'b0000_0100,
		S_SHIFT_RD = 8'b0000_1000,
		S_SHIFT_WR = 8'b0001_0000,
		S_FRONT_WR = 8'b0010_0000,
		S_HEAD_RD  = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [AW-1:0]         head_q;     // physical slot of the queue head
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;      // logical position under search or shift
	logic [1:0]            st_q;
	logic [DATA_WIDTH-1:0] key_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	logic                  mem_we;
	logic                  mem_re;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]         mem_addr;
	logic [CW-1:0]         offset;

	logic                  cmd_xfer;
	logic                  rsp_load;
	logic [DATA_WIDTH+15:0] key_ext;
	logic [DATA_WIDTH-1:0] key_in;
	logic [DATA_WIDTH+15:0] head_ext;
	logic [CW+4:0]         count_ext;
	logic [CW-1:0]         idx_dec;
	logic [CW:0]           idx_nxt;
	logic                  search_last;
	logic                  hit;

	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;

	// store and compare on the low DATA_WIDTH bits of the value, zero extended if wider
	assign key_ext = {{DATA_WIDTH{1'b0}}, cmd.item_value};
	assign key_in  = key_ext[DATA_WIDTH-1:0];

	assign idx_dec     = idx_q - ONE_CNT;
	assign idx_nxt     = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign search_last = (idx_nxt == {1'b0, count_q});
	assign hit         = (rd_data_q == key_q);

	// pick the logical offset for the shared address unit
	always_comb begin
		case (state_q)
			S_IDLE: begin
				if (cmd.operation == OP_ENQ) begin
					offset = count_q;
				end else if (cmd.operation == OP_DEQ) begin
					offset = ONE_CNT;
				end else begin
					offset = '0;
				end
			end
			S_SRCH_RD:  offset = idx_q;
			S_SHIFT_RD: offset = idx_dec;
			S_SHIFT_WR: offset = idx_q;
			default:    offset = '0;
		endcase
	end

	fqmtf_addr_unit #(
		.DEPTH(DEPTH)
	) u_addr (
		.base  (head_q),
		.offset(offset),
		.addr  (mem_addr)
	);

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = key_q;
		case (state_q)
			S_IDLE: begin
				mem_we    = cmd_xfer && (cmd.operation == OP_ENQ) && (count_q != FULL_CNT);
				mem_wdata = key_in;
			end
			S_SRCH_RD:  mem_re = 1'b1;
			S_SHIFT_RD: mem_re = 1'b1;
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rd_data_q;
			end
			S_FRONT_WR: mem_we = 1'b1;
			S_HEAD_RD:  mem_re = (count_q != '0);
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			key_q   <= '0;
			st_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						key_q <= key_in;
						idx_q <= '0;
						st_q  <= ST_OK;
						state_q <= S_HEAD_RD;
						case (cmd.operation)
							OP_ENQ: begin
								if (count_q == FULL_CNT) begin
									st_q <= ST_FULL;
								end else begin
									count_q <= count_q + ONE_CNT;
								end
							end
							OP_DEQ: begin
								if (count_q == '0) begin
									st_q <= ST_EMPTY;
								end else begin
									head_q  <= mem_addr;
									count_q <= count_q - ONE_CNT;
								end
							end
							OP_MTF: begin
								if (count_q == '0) begin
									st_q <= ST_NOTFOUND;
								end else begin
									state_q <= S_SRCH_RD;
								end
							end
							default: begin
								st_q <= ST_OK;
							end
						endcase
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (hit) begin
						// key already at the head leaves the order alone
						state_q <= (idx_q == '0) ? S_HEAD_RD : S_SHIFT_RD;
					end else if (search_last) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_HEAD_RD;
					end else begin
						idx_q   <= idx_nxt[CW-1:0];
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					idx_q   <= idx_dec;
					state_q <= (idx_q == ONE_CNT) ? S_FRONT_WR : S_SHIFT_RD;
				end
				S_FRONT_WR: begin
					state_q <= S_HEAD_RD;
				end
				S_HEAD_RD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register: load when the previous result is gone or leaves this cycle
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign head_ext  = {16'b0, rd_data_q};
	assign count_ext = {5'b0, count_q};
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.head_value  <= (count_q == '0) ? '0 : $signed(head_ext[15:0]);
			rsp_q.queue_empty <= (count_q == '0);
			rsp_q.entry_count <= count_ext[4:0];
			rsp_q.status      <= st_q;
		end
	end

`ifndef SYNTHESIS
	// occupancy never runs past the RAM depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("entry count exceeds depth");

	// a transfer starts a multi-cycle command, so the next cycle is busy
	assert property (@(posedge clk) disable iff (!arst_n) cmd_xfer |=> !cmd_ready)
		else $error("command port ready right after a transfer");

	// occupancy changes only on a command transfer
	assert property (@(posedge clk) disable iff (!arst_n) !cmd_xfer |=> $stable(count_q))
		else $error("entry count changed without a command");

	// the search never walks past the last held entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_CMP) |-> (idx_q < count_q))
		else $error("search index beyond occupancy");
`endif

endmodule

>>> bench/fifo_queue_move_to_front_test.sv
module fifo_queue_move_to_front_test
	import fqmtf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	// Longest command is a move-to-front that finds its key at the tail.
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 550;

	// Shadow copy of the queue: it predicts each response and holds the
	// responses that are still due from the block, oldest first.
	class queue_tracker;
		logic signed [15:0] slots[$];
		rsp_item_t          expected_rsp[$];
		int                 fails;

		function new();
			fails = 0;
		endfunction

		function rsp_item_t apply_command(cmd_item_t c);
			rsp_item_t  r;
			logic [1:0] st;
			int         pos;
			st  = ST_OK;
			pos = 0;
			case (c.operation)
				OP_ENQ: begin
					if (slots.size() >= DEPTH_DEF)
						st = ST_FULL;
					else
						slots.push_back(c.item_value);
				end
				OP_DEQ: begin
					if (slots.size() == 0)
						st = ST_EMPTY;
					else
						void'(slots.pop_front());
				end
				OP_MTF: begin
					if (slots.size() == 0) begin
						st = ST_NOTFOUND;
					end else if (slots[0] != c.item_value) begin
						for (int i = 1; i < slots.size() && pos == 0; i++)
							if (slots[i] == c.item_value)
								pos = i;
						if (pos == 0) begin
							st = ST_NOTFOUND;
						end else begin
							slots.delete(pos);
							slots.push_front(c.item_value);
						end
					end
				end
				default: ;
			endcase
			r.head_value  = (slots.size() > 0) ? slots[0] : 16'sd0;
			r.queue_empty = (slots.size() == 0);
			r.entry_count = 5'(slots.size());
			r.status      = st;
			return r;
		endfunction

		function void note_command(cmd_item_t c);
			expected_rsp.push_back(apply_command(c));
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (expected_rsp.size() == 0) begin
				$error("response transfer with nothing expected");
				fails++;
				return;
			end
			want = expected_rsp.pop_front();
			compare_field("head_value", want.head_value, got.head_value);
			compare_field("queue_empty", want.queue_empty, got.queue_empty);
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	// Stimulus styles of the random part: grow toward full, shrink toward
	// empty, or a mix weighted toward move-to-front.
	typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } stim_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	queue_tracker sb = new();

	int cycle_count = 0;
	int burst_left  = 0;
	int stall_mode  = 0;
	int stall_left  = 0;

	// Small pool so that keys repeat and searches hit; the extremes are in it.
	logic signed [15:0] value_pool[8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
		16'sh0001, 16'sh0002, 16'sh0005, 16'sh0064};

	fifo_queue_move_to_front u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[fifo_queue_move_to_front] ERROR");
			$finish;
		end
	end

	// Response side: check every transfer, then pick the next ready value.
	// Stretches of always-ready, coin-flip stalls and long stalls take turns.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp);
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(10, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0:       rsp_ready <= 1'b1;
			1:       rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic logic signed [15:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, 7)];
		return 16'($urandom);
	endfunction

	// Build the next random command against the current shadow contents, so
	// most move-to-front keys are present: at the head, the tail or anywhere.
	function automatic cmd_item_t pick_command(stim_mode_t mode);
		cmd_item_t c;
		int        roll;
		int        n;
		int        sel;
		n    = sb.slots.size();
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:
				c.operation = (roll < 70) ? OP_ENQ : (roll < 82) ? OP_MTF :
					(roll < 92) ? OP_DEQ : OP_PEEK;
			MODE_DRAIN:
				c.operation = (roll < 55) ? OP_DEQ : (roll < 70) ? OP_ENQ :
					(roll < 88) ? OP_MTF : OP_PEEK;
			default:
				c.operation = (roll < 30) ? OP_ENQ : (roll < 55) ? OP_DEQ :
					(roll < 90) ? OP_MTF : OP_PEEK;
		endcase
		c.item_value = pick_value();
		if (c.operation == OP_MTF && n > 0 && $urandom_range(0, 9) < 7) begin
			sel = $urandom_range(0, 3);
			if (sel == 0)
				c.item_value = sb.slots[0];
			else if (sel == 1)
				c.item_value = sb.slots[n - 1];
			else
				c.item_value = sb.slots[$urandom_range(0, n - 1)];
		end
		return c;
	endfunction

	// Present one command, hold it until the transfer, note it, then either
	// keep valid up for the rest of the burst or drop it for a random gap.
	task automatic issue(cmd_item_t c);
		int gap;
		cmd       <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		sb.note_command(c);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 12);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic issue_op(logic [1:0] op, logic signed [15:0] value);
		cmd_item_t c;
		c.operation  = op;
		c.item_value = value;
		issue(c);
	endtask

	initial begin
		stim_mode_t mode;
		int         seg_left;

		// Hold reset, then release it on an edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: peek, dequeue and move-to-front on an empty queue.
		issue_op(OP_PEEK, 16'sh5a5a);
		issue_op(OP_DEQ, 16'sh0000);
		issue_op(OP_MTF, 16'sh0000);
		// Single entry: key at the head, then a key missing from a one-entry queue.
		issue_op(OP_ENQ, 16'sh7fff);
		issue_op(OP_MTF, 16'sh7fff);
		issue_op(OP_MTF, 16'sh8000);
		// Found at the tail, found at the tail again, not found.
		issue_op(OP_ENQ, 16'sh8000);
		issue_op(OP_ENQ, 16'sh0000);
		issue_op(OP_ENQ, 16'shffff);
		issue_op(OP_MTF, 16'shffff);
		issue_op(OP_MTF, 16'sh0000);
		issue_op(OP_MTF, 16'sh04d2);
		// Fill to capacity with a duplicate key, drop one on full, then pull
		// the last slot to the front for the longest search.
		for (int i = 0; i < DEPTH_DEF - 4; i++)
			issue_op(OP_ENQ, (i == 5) ? 16'sh0000 : 16'(16'sh0100 * (i + 1) + i));
		issue_op(OP_ENQ, 16'sh1234);
		issue_op(OP_MTF, 16'(16'sh0100 * (DEPTH_DEF - 4) + DEPTH_DEF - 5));

		// Random: segments of one style each, with random content.
		seg_left = 0;
		mode     = MODE_DRAIN;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				mode     = stim_mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(10, 40);
			end
			seg_left--;
			issue(pick_command(mode));
		end
		cmd_valid <= 1'b0;

		// Wait for every response, then let the block settle.
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.fails == 0)
			$display("[fifo_queue_move_to_front] OK");
		else
			$display("[fifo_queue_move_to_front] ERROR");
		$finish;
	end

endmodule
